[src/tdp_pkg.sv]
// shared constants and types for the trial division primality test unit
package tdp_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic done;         // one-cycle pulse, fields below are valid with it
    logic rem_zero;     // remainder is zero
    logic quot_ge_div;  // quotient >= divisor, i.e. divisor*divisor <= dividend
  } div_status_t;

endpackage

[src/tdp_divider.sv]
// iterative restoring divider, one quotient bit per cycle
module tdp_divider import tdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  value_t      dividend_i,
  input  value_t      divisor_i,
  output div_status_t status_o
);

  value_t           rem_q, rem_d;
  value_t           quot_q, quot_d;
  value_t           dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH:0] diff;

  assign shifted = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(VALUE_WIDTH - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restore when the trial subtraction goes negative
      if (diff[VALUE_WIDTH]) begin
        rem_d  = shifted[VALUE_WIDTH-1:0];
        quot_d = {quot_q[VALUE_WIDTH-2:0], 1'b0};
      end else begin
        rem_d  = diff[VALUE_WIDTH-1:0];
        quot_d = {quot_q[VALUE_WIDTH-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign status_o.done        = done_q;
  assign status_o.rem_zero    = (rem_q == '0);
  assign status_o.quot_ge_div = (quot_q >= dvs_q);

endmodule

[src/trial_division_primality_test_unit.sv]
// trial division primality test: sequencer around a shared iterative divider
// candidates <= 2, even or with the top bit set are settled without the divider; others
//   run the divider once per odd trial divisor from 3 until one divides or passes the root
// one transaction at a time: the input is taken only while idle, after the previous
//   result has been reported; three itself runs one trial divisor
// a result waiting in the output register does not block the next transaction
// reset (rst_ni low, asynchronous) returns the sequencer to idle and drops m_axis_tvalid
module trial_division_primality_test_unit import tdp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [VALUE_WIDTH-1:0] candidate
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] prime flag
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCheck  = 3'd1;
  localparam logic [2:0] StStart  = 3'd2;
  localparam logic [2:0] StWait   = 3'd3;
  localparam logic [2:0] StReport = 3'd4;

  logic [2:0]  state_q, state_d;
  value_t      cand_q, cand_d;
  value_t      div_q, div_d;
  logic        res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic        out_prime_q, out_prime_d;
  logic        div_start;
  div_status_t div_status;

  tdp_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(cand_q),
    .divisor_i (div_q),
    .status_o  (div_status)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign div_start     = (state_q == StStart);

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    div_d       = div_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cand_d  = s_axis_tdata[VALUE_WIDTH-1:0];
          state_d = StCheck;
        end
      end
      StCheck: begin
        state_d = StReport;
        if (cand_q[VALUE_WIDTH-1] || cand_q <= VALUE_WIDTH'(1)) begin
          res_d = 1'b0;
        end else if (cand_q == VALUE_WIDTH'(2)) begin
          res_d = 1'b1;
        end else if (!cand_q[0]) begin
          res_d = 1'b0;
        end else begin
          div_d   = VALUE_WIDTH'(3);
          state_d = StStart;
        end
      end
      StStart: begin
        state_d = StWait;
      end
      StWait: begin
        if (div_status.done) begin
          if (!div_status.quot_ge_div) begin
            // divisor passed the square root
            res_d   = 1'b1;
            state_d = StReport;
          end else if (div_status.rem_zero) begin
            res_d   = 1'b0;
            state_d = StReport;
          end else begin
            div_d   = div_q + VALUE_WIDTH'(2);
            state_d = StStart;
          end
        end
      end
      StReport: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_prime_d = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    div_q       <= div_d;
    res_q       <= res_d;
    out_prime_q <= out_prime_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_prime_q};

endmodule

[test/tb.sv]
// self-checking testbench for the trial division primality test unit
module tb import tdp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // the slowest candidate, 2^31-1, runs about 23170 trial divisors
  localparam int unsigned STALL_LIMIT   = 4_000_000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned RANDOM_PER_PH = 180;

  class verdict_tracker;
    value_t pending_candidates[$];
    bit     pending_verdicts[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // odd divisors from 3 while divisor <= candidate / divisor
    function bit trial_divide_prime(value_t candidate);
      value_t divisor;
      if (candidate[VALUE_WIDTH-1]) return 1'b0;
      if (candidate <= value_t'(1)) return 1'b0;
      if (candidate == value_t'(2)) return 1'b1;
      if (!candidate[0]) return 1'b0;
      for (divisor = 3; divisor <= candidate / divisor; divisor += 2) begin
        if (candidate % divisor == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(value_t candidate);
      pending_candidates.push_back(candidate);
      pending_verdicts.push_back(trial_divide_prime(candidate));
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic prime_flag);
      value_t candidate;
      bit     want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("prime flag %b arrived with no candidate pending", prime_flag));
        return;
      end
      candidate = pending_candidates.pop_front();
      want      = pending_verdicts.pop_front();
      if (prime_flag !== want)
        report($sformatf("candidate %0d: prime flag %b, want %0b",
                         $signed(candidate), prime_flag, want));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [VALUE_WIDTH-1:0] candidate
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [0] prime flag

  verdict_tracker board;
  int unsigned    src_idle_pct;
  int unsigned    snk_idle_pct;
  bit             hold_req;

  trial_division_primality_test_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random back-pressure, plus a long hold-off when requested
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata[0]);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ends the run if no transaction moves on either side for too long
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_candidate(value_t candidate);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(candidate);
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_candidate(candidate);
  endtask

  // the sender stops offering while it waits
  task automatic wait_for_verdicts();
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // mostly small values so the divider loop stays short
  function automatic value_t random_candidate();
    value_t      v;
    int unsigned pick;
    int unsigned factor;
    pick   = $urandom_range(99);
    factor = 3 + 2 * $urandom_range(0, 5);
    if (pick < 55) begin
      v = $urandom_range(0, 4095);
    end else if (pick < 70) begin
      v = 2 * $urandom_range(0, 2047) + 1;
    end else if (pick < 75) begin
      v = $urandom_range(4096, 65535);
    end else if (pick < 85) begin
      v = $urandom();
      v[VALUE_WIDTH-1] = 1'b1;
    end else if (pick < 92) begin
      v = $urandom();
      v[VALUE_WIDTH-1] = 1'b0;
      v[0] = 1'b0;
    end else begin
      // large odd value with a small factor, settled after a few divisors
      v = $urandom();
      v[VALUE_WIDTH-1] = 1'b0;
      v = v - v % factor;
      if (!v[0]) v = v + factor;
    end
    return v;
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_candidate(random_candidate());
  endtask

  initial begin
    value_t directed[$];
    board         = new();
    hold_req      = 1'b0;
    src_idle_pct  = 30;
    snk_idle_pct  = 54;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, one, two, three, small primes, squares of primes, negatives, range ends
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15,
                 32'd25, 32'd49, 32'd97, 32'd121, 32'd65521, 32'd65535,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h7FFF_FFFD, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
    foreach (directed[i]) send_candidate(directed[i]);
    wait_for_verdicts();
    send_random(RANDOM_PER_PH);

    // receiver stalls while the sender keeps offering, so the input backs up
    hold_req = 1'b1;
    repeat (12) send_candidate($urandom_range(0, 255));

    src_idle_pct = 54;
    snk_idle_pct = 30;
    send_random(RANDOM_PER_PH);
    wait_for_verdicts();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(RANDOM_PER_PH);
    s_axis_tvalid <= 1'b0;

    wait_for_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
